### hw/rtl/variable_partition_allocator_unit_defines.svh
// Assertion macros for the partition allocator.
`ifndef VARIABLE_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define VPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define VPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/vpa_pkg.sv
package vpa_pkg;

  localparam int unsigned MaxPartitions = 64;
  localparam logic [31:0] MemSizeReset  = 32'd65536;

  typedef enum logic [1:0] {
    CmdAlloc     = 2'd0,
    CmdFreeOwner = 2'd1,
    CmdFreeStart = 2'd2,
    CmdQuery     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoFit    = 2'd1,
    StFull     = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FitFirst = 2'd0,
    FitBest  = 2'd1,
    FitWorst = 2'd2
  } fit_e;

  localparam logic CfgFitPolicy  = 1'b0;
  localparam logic CfgMemorySize = 1'b1;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic        used;
    logic [15:0] owner;
    logic [31:0] length;
    logic [31:0] start;
  } entry_t;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### hw/rtl/variable_partition_allocator_unit.sv
// Variable partition allocator.
// Input channel s_axis_*: one request per item (allocate, free by owner,
// free by start, query owner). Output channel m_axis_*: one result per
// request (status, base, size, limit). Configuration: cfg_we_i writes
// fit_policy (index 0) or memory_size (index 1); writing memory_size resets
// the table to one free partition. Write only while idle.
// The table lives in one synchronous memory of MAX_PARTITIONS entries; each
// command walks it entry by entry through the single read port.
// Every command scans all N entries (N the current entry count); an allocate
// that splits entry k then shifts the entries above k up by one, and free by
// owner adds a compaction pass that merges adjacent free entries. One request in
// flight at a time; the next is taken the cycle after the result is handed over.
// Reset: one free entry [0, 65536), first fit. Reset needs no clearing pass:
// entries beyond the count are never read.
// A stalled receiver holds the result register; the next request is taken
// once the result has been handed over.
`include "variable_partition_allocator_unit_defines.svh"

module variable_partition_allocator_unit #(
  parameter int unsigned MAX_PARTITIONS = vpa_pkg::MaxPartitions
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] cmd, [33:2] req_size, [49:34] owner_id, [81:50] start_addr, zero pad
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] status, [33:2] part_base, [65:34] part_size, [97:66] part_limit
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int unsigned IW = $clog2(MAX_PARTITIONS);
  localparam int unsigned CW = $clog2(MAX_PARTITIONS + 1);
  localparam logic [CW-1:0] CountMax = CW'(MAX_PARTITIONS);

  typedef enum logic [8:0] {
    SIdle    = 9'b000000001,
    SScan    = 9'b000000010,
    SDecide  = 9'b000000100,
    SShiftRd = 9'b000001000,
    SShiftWr = 9'b000010000,
    SFinish  = 9'b000100000,
    SMergeRd = 9'b001000000,
    SMergeWr = 9'b010000000,
    SOut     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Table memory, one read and one write port.
  vpa_pkg::entry_t mem [MAX_PARTITIONS];
  logic            we;
  logic [IW-1:0]   waddr, raddr;
  vpa_pkg::entry_t wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Config and table bookkeeping.
  logic [1:0]  fit_q;
  logic [31:0] msize_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic        init_q;          // entry 0 written in the first cycle after reset

  // Request fields.
  logic [1:0]  cmd_q;
  logic [31:0] req_q, saddr_q;
  logic [15:0] own_q;

  // Scan controls.
  logic [CW-1:0] ra_q, ra_d;    // next address to read
  logic          rv_q, rv_d;    // rdata_q holds entry at ri_q
  logic [IW-1:0] ri_q, ri_d;
  logic          hit_q, hit_d;
  logic [IW-1:0] k_q, k_d;
  vpa_pkg::entry_t ke_q, ke_d;  // chosen entry
  vpa_pkg::entry_t acc_q, acc_d; // merge accumulator
  logic [CW-1:0] wi_q, wi_d;    // merge write pointer
  logic          seen_q, seen_d;
  logic [CW-1:0] sh_q, sh_d;    // shift pointer

  logic [1:0]  st_q, st_d;
  logic [31:0] base_q, base_d, size_q, size_d, lim_q, lim_d;
  logic        ovalid_q, ovalid_d;

  assign s_axis_tready = (state_q == SIdle) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, lim_q, size_q, base_q, st_q};

  logic            match;
  logic [31:0]     rest;
  vpa_pkg::entry_t init_e;

  always_comb begin
    init_e = '0;
    init_e.length = msize_q;
    rest = ke_q.length - req_q;
    match = 1'b0;
    unique case (vpa_pkg::cmd_e'(cmd_q))
      vpa_pkg::CmdAlloc: begin
        match = !rdata_q.used && rdata_q.length >= req_q;
        if (match && hit_q) begin
          case (fit_q)
            vpa_pkg::FitBest:  match = rdata_q.length < ke_q.length;
            vpa_pkg::FitWorst: match = rdata_q.length > ke_q.length;
            default:           match = 1'b0;
          endcase
        end
      end
      vpa_pkg::CmdFreeStart: match = !hit_q && rdata_q.used && rdata_q.start == saddr_q;
      default:               match = !hit_q && rdata_q.used && rdata_q.owner == own_q;
    endcase
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q;
    ra_d = ra_q; rv_d = 1'b0; ri_d = ri_q;
    hit_d = hit_q; k_d = k_q; ke_d = ke_q; acc_d = acc_q;
    wi_d = wi_q; seen_d = seen_q; sh_d = sh_q;
    st_d = st_q; base_d = base_q; size_d = size_q; lim_d = lim_q;
    ovalid_d = ovalid_q;
    we = 1'b0; waddr = '0; wdata = rdata_q; raddr = ra_q[IW-1:0];
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      SIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          ra_d = '0; hit_d = 1'b0;
          state_d = SScan;
        end
      end
      SScan: begin
        // issue reads, evaluate returned entries
        if (ra_q < cnt_q) begin
          raddr = ra_q[IW-1:0];
          rv_d = 1'b1; ri_d = ra_q[IW-1:0];
          ra_d = ra_q + 1'b1;
        end
        if (rv_q && match) begin
          hit_d = 1'b1; k_d = ri_q; ke_d = rdata_q;
        end
        if (!rv_q && ra_q >= cnt_q) begin
          state_d = SDecide;
        end
      end
      SDecide: begin
        base_d = '0; size_d = '0; lim_d = '0; st_d = vpa_pkg::StOk;
        state_d = SOut;
        if (!hit_q) begin
          st_d = (cmd_q == vpa_pkg::CmdAlloc) ? vpa_pkg::StNoFit : vpa_pkg::StNotFound;
        end else begin
          unique case (vpa_pkg::cmd_e'(cmd_q))
            vpa_pkg::CmdAlloc: begin
              if (rest != '0 && cnt_q >= CountMax) begin
                st_d = vpa_pkg::StFull;
              end else begin
                base_d = ke_q.start; size_d = req_q;
                lim_d = vpa_pkg::sat_add(ke_q.start, req_q);
                we = 1'b1; waddr = k_q;
                wdata = '{used: 1'b1, owner: own_q, length: req_q, start: ke_q.start};
                if (rest != '0) begin
                  sh_d = cnt_q;
                  state_d = SShiftRd;
                end
              end
            end
            vpa_pkg::CmdQuery: begin
              base_d = ke_q.start; size_d = ke_q.length;
              lim_d = vpa_pkg::sat_add(ke_q.start, ke_q.length);
            end
            vpa_pkg::CmdFreeStart: begin
              we = 1'b1; waddr = k_q;
              wdata = ke_q; wdata.used = 1'b0; wdata.owner = '0;
            end
            default: begin
              we = 1'b1; waddr = k_q;
              wdata = ke_q; wdata.used = 1'b0; wdata.owner = '0;
              ra_d = '0; wi_d = '0; seen_d = 1'b0;
              state_d = SMergeRd;
            end
          endcase
        end
      end
      SShiftRd: begin
        // move entry sh-1 to sh, down to k+1
        if (sh_q > CW'(k_q) + 1'b1) begin
          raddr = IW'(sh_q - 1'b1);
          state_d = SShiftWr;
        end else begin
          state_d = SFinish;
        end
      end
      SShiftWr: begin
        we = 1'b1; waddr = sh_q[IW-1:0]; wdata = rdata_q;
        sh_d = sh_q - 1'b1;
        state_d = SShiftRd;
      end
      SFinish: begin
        we = 1'b1; waddr = IW'(CW'(k_q) + 1'b1);
        wdata = '{used: 1'b0, owner: '0, length: rest, start: ke_q.start + req_q};
        cnt_d = cnt_q + 1'b1;
        state_d = SOut;
      end
      SMergeRd: begin
        // read entry ra, combine into acc; then write out compacted rows
        if (ra_q < cnt_q) begin
          raddr = ra_q[IW-1:0];
          state_d = SMergeWr;
        end else begin
          we = seen_q; waddr = wi_q[IW-1:0]; wdata = acc_q;
          cnt_d = wi_q + 1'b1;
          state_d = SOut;
        end
      end
      SMergeWr: begin
        ra_d = ra_q + 1'b1;
        state_d = SMergeRd;
        if (!seen_q) begin
          acc_d = rdata_q; seen_d = 1'b1;
        end else if (!acc_q.used && !rdata_q.used) begin
          acc_d.length = acc_q.length + rdata_q.length;
        end else begin
          we = 1'b1; waddr = wi_q[IW-1:0]; wdata = acc_q;
          wi_d = wi_q + 1'b1; acc_d = rdata_q;
        end
      end
      SOut: begin
        ovalid_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    if (init_q) begin
      we = 1'b1; waddr = '0; wdata = init_e;
    end
    if (cfg_we_i && cfg_index_i == vpa_pkg::CfgMemorySize) begin
      we = 1'b1; waddr = '0;
      wdata = '0; wdata.length = cfg_wdata_i;
      cnt_d = CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= CW'(1); ovalid_q <= 1'b0;
      fit_q <= vpa_pkg::FitFirst; msize_q <= vpa_pkg::MemSizeReset;
      rv_q <= 1'b0; hit_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovalid_q <= ovalid_d;
      rv_q <= rv_d; hit_q <= hit_d;
      if (cfg_we_i) begin
        if (cfg_index_i == vpa_pkg::CfgFitPolicy) fit_q <= cfg_wdata_i[1:0];
        else msize_q <= cfg_wdata_i;
      end
    end
  end

  // Entry 0 after reset: written once in the first cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) init_q <= 1'b1;
    else init_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    ra_q <= ra_d; ri_q <= ri_d; k_q <= k_d; ke_q <= ke_d; acc_q <= acc_d;
    wi_q <= wi_d; seen_q <= seen_d; sh_q <= sh_d;
    st_q <= st_d; base_q <= base_d; size_q <= size_d; lim_q <= lim_d;
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tdata[1:0]; req_q <= s_axis_tdata[33:2];
      own_q <= s_axis_tdata[49:34]; saddr_q <= s_axis_tdata[81:50];
    end
  end

  `VPA_ASSERT(a_count_range, clk_i, rst_ni, cnt_q >= CW'(1) && cnt_q <= CountMax,
    "entry count out of range")
  `VPA_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `VPA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
  `VPA_ASSERT_NEXT(a_grow, clk_i, rst_ni, state_q == SFinish && !cfg_we_i,
    cnt_q == $past(cnt_q) + 1'b1, "split did not add entry")

endmodule

### sim/tb_top.sv
module tb_top;

  localparam int unsigned NumParts   = vpa_pkg::MaxPartitions;
  localparam int unsigned RandReqs   = 500;
  localparam int unsigned IdleLimit  = 4000;
  // Settle time waited in drain() after the last pending result.
  localparam int unsigned SettleCyc  = 4 * NumParts + 20;

  typedef struct packed {
    logic [31:0]       limit;
    logic [31:0]       size;
    logic [31:0]       base;
    vpa_pkg::status_e  status;
  } result_t;

  // Shadow of the partition table plus a FIFO of pending results.
  class alloc_scoreboard;
    logic [31:0] start_q [NumParts];
    logic [31:0] len_q [NumParts];
    bit          used_q [NumParts];
    logic [15:0] owner_q [NumParts];
    int unsigned count;
    logic [1:0]  policy;
    logic [31:0] mem_size;
    result_t     pending [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned full_hits;

    function void table_init();
      foreach (used_q[i]) begin
        used_q[i] = 0;
        owner_q[i] = 0;
        start_q[i] = 0;
        len_q[i] = 0;
      end
      len_q[0] = mem_size;
      count = 1;
    endfunction

    function void reset_state();
      policy = vpa_pkg::FitFirst;
      mem_size = vpa_pkg::MemSizeReset;
      pending.delete();
      errors = 0;
      checked = 0;
      full_hits = 0;
      table_init();
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
      if (idx == vpa_pkg::CfgFitPolicy) policy = val[1:0];
      else begin
        mem_size = val;
        table_init();
      end
    endfunction

    function int unsigned owner_slot(logic [15:0] who);
      for (int unsigned i = 0; i < count; i++)
        if (used_q[i] && owner_q[i] == who) return i;
      return count;
    endfunction

    function void copy_slot(int unsigned d, int unsigned s);
      start_q[d] = start_q[s];
      len_q[d] = len_q[s];
      used_q[d] = used_q[s];
      owner_q[d] = owner_q[s];
    endfunction

    function void merge_free_runs();
      int unsigned i;
      i = 0;
      while (i + 1 < count) begin
        if (!used_q[i] && !used_q[i+1]) begin
          len_q[i] = len_q[i] + len_q[i+1];
          for (int unsigned j = i + 1; j + 1 < count; j++) copy_slot(j, j + 1);
          count--;
        end else i++;
      end
    endfunction

    function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Note an accepted request and queue the result it must produce.
    function void note_request(vpa_pkg::cmd_e op, logic [31:0] req, logic [15:0] who,
                               logic [31:0] saddr);
      result_t r;
      int unsigned k;
      logic [31:0] rest;
      r = '0;
      r.status = vpa_pkg::StOk;
      case (op)
        vpa_pkg::CmdAlloc: begin
          k = count;
          for (int unsigned i = 0; i < count; i++) begin
            if (used_q[i] || len_q[i] < req) continue;
            if (k == count) begin
              k = i;
              if (policy != vpa_pkg::FitBest && policy != vpa_pkg::FitWorst) break;
            end else if (policy == vpa_pkg::FitBest && len_q[i] < len_q[k]) k = i;
            else if (policy == vpa_pkg::FitWorst && len_q[i] > len_q[k]) k = i;
          end
          if (k >= count) r.status = vpa_pkg::StNoFit;
          else begin
            rest = len_q[k] - req;
            if (rest != 0 && count >= NumParts) begin
              r.status = vpa_pkg::StFull;
              full_hits++;
            end else begin
              used_q[k] = 1;
              owner_q[k] = who;
              len_q[k] = req;
              if (rest != 0) begin
                for (int unsigned i = count; i > k + 1; i--) copy_slot(i, i - 1);
                start_q[k+1] = start_q[k] + req;
                len_q[k+1] = rest;
                used_q[k+1] = 0;
                owner_q[k+1] = 0;
                count++;
              end
              r.base = start_q[k];
              r.size = req;
              r.limit = sat_sum(r.base, req);
            end
          end
        end
        vpa_pkg::CmdFreeOwner: begin
          k = owner_slot(who);
          if (k >= count) r.status = vpa_pkg::StNotFound;
          else begin
            used_q[k] = 0;
            owner_q[k] = 0;
            merge_free_runs();
          end
        end
        vpa_pkg::CmdFreeStart: begin
          r.status = vpa_pkg::StNotFound;
          for (int unsigned i = 0; i < count; i++)
            if (used_q[i] && start_q[i] == saddr) begin
              used_q[i] = 0;
              owner_q[i] = 0;
              r.status = vpa_pkg::StOk;
              break;
            end
        end
        default: begin
          k = owner_slot(who);
          if (k >= count) r.status = vpa_pkg::StNotFound;
          else begin
            r.base = start_q[k];
            r.size = len_q[k];
            r.limit = sat_sum(r.base, r.size);
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [103:0] data);
      result_t got, exp;
      got = data[97:0];
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.base !== exp.base) begin
        $display("%0t: base exp %h got %h", $time, exp.base, got.base);
        errors++;
      end
      if (got.size !== exp.size) begin
        $display("%0t: size exp %h got %h", $time, exp.size, got.size);
        errors++;
      end
      if (got.limit !== exp.limit) begin
        $display("%0t: limit exp %h got %h", $time, exp.limit, got.limit);
        errors++;
      end
      if (data[103:98] !== '0) begin
        $display("%0t: pad bits exp 0 got %h", $time, data[103:98]);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // [1:0] cmd, [33:2] req_size, [49:34] owner_id, [81:50] start_addr, zero pad
  logic [87:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [1:0] status, [33:2] part_base, [65:34] part_size, [97:66] part_limit
  logic [103:0] m_axis_tdata;
  logic         cfg_we_i;
  logic         cfg_index_i;
  logic [31:0]  cfg_wdata_i;

  variable_partition_allocator_unit dut (.*);

  alloc_scoreboard sb;
  int unsigned idle_cycles = 0;
  int unsigned sent;
  bit          rx_hold;     // long receiver stall window
  bit          rx_nogaps;   // stretches with no receiver idling
  bit          tx_nogaps;
  logic [15:0] live_owners [$];
  logic [31:0] live_starts [$];

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random tready gaps, plus a hold-off window on request.
  initial begin
    int unsigned gap;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold) m_axis_tready <= 0;
      else if (m_axis_tvalid && m_axis_tready) begin
        gap = rx_nogaps ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
          m_axis_tready <= 0;
          repeat (gap - 1) @(posedge clk_i);
          @(posedge clk_i);
        end
        m_axis_tready <= 1;
      end else m_axis_tready <= 1;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  // Drive one request and note it with the scoreboard on acceptance.
  // tvalid stays up after acceptance until the next gap or drain; the block
  // holds tready low after every accepted request until its result is handed over.
  task automatic send_req(vpa_pkg::cmd_e op, logic [31:0] req, logic [15:0] who,
                          logic [31:0] saddr);
    int unsigned gap;
    gap = tx_nogaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {6'd0, saddr, who, req, op};
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, req, who, saddr);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Register write between phases, block idle.
  task automatic write_reg(logic idx, logic [31:0] val);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, val);
    live_owners.delete();
    live_starts.delete();
  endtask

  // Mostly sensible traffic: allocate, then free or query known owners.
  task automatic random_req(logic [31:0] size_span);
    int unsigned pick, idx;
    logic [15:0] who;
    logic [31:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 45 || live_owners.size() == 0) begin
      who = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      case ($urandom_range(0, 9))
        0: req = $urandom;
        1: req = 0;
        default: req = $urandom_range(1, size_span);
      endcase
      send_req(vpa_pkg::CmdAlloc, req, who, $urandom);
      live_owners.push_back(who);
    end else if (pick < 65) begin
      idx = $urandom_range(0, live_owners.size() - 1);
      send_req(vpa_pkg::CmdFreeOwner, $urandom, live_owners[idx], $urandom);
      live_owners.delete(idx);
    end else if (pick < 75) begin
      // Free by start of a queried owner's base is found via the query reply
      // path being random; approximate with multiples of the size span.
      send_req(vpa_pkg::CmdFreeStart, $urandom, 16'($urandom),
               ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64) * size_span);
    end else if (pick < 95) begin
      idx = $urandom_range(0, live_owners.size() - 1);
      send_req(vpa_pkg::CmdQuery, $urandom, live_owners[idx], $urandom);
    end else
      send_req(vpa_pkg::cmd_e'($urandom_range(1, 3)), $urandom, 16'($urandom), $urandom);
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we_i = 0;
    cfg_index_i = vpa_pkg::CfgFitPolicy;
    cfg_wdata_i = '0;
    rx_hold = 0;
    rx_nogaps = 0;
    tx_nogaps = 0;
    sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset table, all commands, edges of the fields.
    send_req(vpa_pkg::CmdQuery, 0, 16'h0000, 0);                   // not found
    send_req(vpa_pkg::CmdAlloc, 32'hFFFF_FFFF, 16'hFFFF, 0);       // no fit
    send_req(vpa_pkg::CmdAlloc, 0, 16'h0001, 0);                   // zero size
    send_req(vpa_pkg::CmdAlloc, 100, 16'h0002, 0);
    send_req(vpa_pkg::CmdAlloc, 100, 16'h0002, 0);                 // duplicate owner
    send_req(vpa_pkg::CmdQuery, 0, 16'h0002, 0);
    send_req(vpa_pkg::CmdFreeStart, 0, 16'h0000, 100);
    send_req(vpa_pkg::CmdFreeStart, 0, 16'h0000, 32'hFFFF_FFFF);   // unknown start
    send_req(vpa_pkg::CmdFreeOwner, 0, 16'h0002, 0);
    send_req(vpa_pkg::CmdFreeOwner, 0, 16'hBEEF, 0);               // unknown owner
    send_req(vpa_pkg::CmdFreeOwner, 0, 16'h0001, 0);
    send_req(vpa_pkg::CmdAlloc, 65536, 16'h0003, 0);               // exact fit
    send_req(vpa_pkg::CmdQuery, 0, 16'h0003, 0);
    send_req(vpa_pkg::CmdFreeOwner, 0, 16'h0003, 0);

    // Max memory: limit reaches 32'hFFFF_FFFF.
    write_reg(vpa_pkg::CfgMemorySize, 32'hFFFF_FFFF);
    send_req(vpa_pkg::CmdAlloc, 32'h8000_0000, 16'h0010, 0);
    send_req(vpa_pkg::CmdAlloc, 32'h7FFF_FFFF, 16'h0011, 0);
    send_req(vpa_pkg::CmdQuery, 0, 16'h0011, 0);
    // Zero memory size.
    write_reg(vpa_pkg::CfgMemorySize, 0);
    send_req(vpa_pkg::CmdAlloc, 0, 16'h0020, 0);
    send_req(vpa_pkg::CmdAlloc, 1, 16'h0021, 0);

    // Fill the table to hit table full, then free all via free by start.
    write_reg(vpa_pkg::CfgMemorySize, 32'd1000);
    for (int i = 0; i < NumParts + 1; i++)
      send_req(vpa_pkg::CmdAlloc, 1, 16'(i), 0);
    tx_nogaps = 1;
    for (int i = 0; i < 64; i++) send_req(vpa_pkg::CmdFreeStart, 0, 16'h0000, i);
    tx_nogaps = 0;

    // Random phases over each policy, including the unnamed value 3.
    for (int ph = 0; ph < 8; ph++) begin
      logic [31:0] msz, span;
      write_reg(vpa_pkg::CfgFitPolicy, ph % 4);
      case (ph % 3)
        0: msz = 32'd4096;
        1: msz = $urandom;
        default: msz = 32'd512;
      endcase
      write_reg(vpa_pkg::CfgMemorySize, msz);
      span = (msz / 24) + 1;
      rx_nogaps = (ph == 2);
      tx_nogaps = (ph == 2 || ph == 5);
      for (int n = 0; n < RandReqs / 8; n++) begin
        if (ph == 4 && n == 10) begin
          // Long receiver hold-off while requests keep coming.
          fork
            begin
              rx_hold = 1;
              repeat (300) @(posedge clk_i);
              rx_hold = 0;
            end
          join_none
        end
        random_req(span);
      end
    end

    drain();
    $display("covered %0d requests, %0d results checked, %0d table-full refusals",
             sent, sb.checked, sb.full_hits);
    $display("all four fit policies, memory sizes 0 to max, long output stall");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### variable_partition_allocator_unit.f
+incdir+hw/rtl
hw/rtl/vpa_pkg.sv
hw/rtl/variable_partition_allocator_unit.sv
sim/tb_top.sv
